### design/neighbor_difference_edge_map_top_defines.svh
// ----------------------------------------------------------------------------
// Neighbor difference edge map: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_DIFFERENCE_EDGE_MAP_TOP_DEFINES_SVH
`define NEIGHBOR_DIFFERENCE_EDGE_MAP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NDEM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NDEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NDEM_ASSERT(lbl, clk, rst, prop, msg)
`define NDEM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/ndem_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor difference edge map package
// Sizes, register map, gray weights and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ndem_pkg;

   localparam int MAX_COLS  = 4096;
   localparam int MAX_ROWS  = 4096;
   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int ROW_BITS  = $clog2(MAX_ROWS);
   localparam int CFG_BITS  = 13;
   localparam int GRAY_BITS = 8;
   localparam int POS_BITS  = 12;
   localparam int ACC_BITS  = 16 + GRAY_BITS;
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   localparam logic [15:0] WEIGHT_RED   = 16'd19661;
   localparam logic [15:0] WEIGHT_GREEN = 16'd38666;
   localparam logic [15:0] WEIGHT_BLUE  = 16'd7209;

   localparam logic [CFG_BITS-1:0]  COLS_RESET      = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0]  ROWS_RESET      = CFG_BITS'(480);
   localparam logic [GRAY_BITS-1:0] THRESHOLD_RESET = GRAY_BITS'(16);
   localparam logic [CFG_BITS-1:0]  SIZE_MIN        = CFG_BITS'(3);
   localparam logic [CFG_BITS-1:0]  COLS_MAX        = CFG_BITS'(MAX_COLS);
   localparam logic [CFG_BITS-1:0]  ROWS_MAX        = CFG_BITS'(MAX_ROWS);

   localparam logic [7:0] COLOR_WHITE = 8'd255;
   localparam logic [7:0] COLOR_BLACK = 8'd0;

   localparam logic [1:0] REG_IMAGE_COLS     = 2'd0;
   localparam logic [1:0] REG_IMAGE_ROWS     = 2'd1;
   localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

   typedef struct packed {
      logic                rd_en;
      logic [COL_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [COL_BITS-1:0] wr_addr;
   } lb_ctrl_type;

endpackage

`default_nettype wire

### design/ndem_if.sv
// ----------------------------------------------------------------------------
// Neighbor difference edge map stream interfaces
// Valid/ready channels for source pixels and edge map results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ndem_req_if
   import ndem_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       frame_start;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, frame_start, red, green, blue, input ready);
   modport sink   (input valid, frame_start, red, green, blue, output ready);
endinterface

interface ndem_rsp_if
   import ndem_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [7:0]          out_red;
   logic [7:0]          out_green;
   logic [7:0]          out_blue;
   logic                edge_found;
   logic [POS_BITS-1:0] pixel_row;
   logic [POS_BITS-1:0] pixel_col;
   logic                frame_last;

   modport source (output valid, out_red, out_green, out_blue, edge_found,
                   pixel_row, pixel_col, frame_last, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, edge_found,
                   pixel_row, pixel_col, frame_last, output ready);
endinterface

`default_nettype wire

### design/ndem_line_buf.sv
// ----------------------------------------------------------------------------
// Neighbor difference edge map line buffers
// Upper and middle gray rows with registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "neighbor_difference_edge_map_top_defines.svh"

module ndem_line_buf
   import ndem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lb_ctrl_type          ctrl,
   input  wire logic [GRAY_BITS-1:0] wr_gray,
   output logic      [GRAY_BITS-1:0] top_gray,
   output logic      [GRAY_BITS-1:0] mid_gray
);

   logic [GRAY_BITS-1:0] upper_mem  [MAX_COLS];
   logic [GRAY_BITS-1:0] middle_mem [MAX_COLS];

   logic [GRAY_BITS-1:0] upper_q_ff;
   logic [GRAY_BITS-1:0] middle_q_ff;
   logic [GRAY_BITS-1:0] fwd_top_ff;
   logic [GRAY_BITS-1:0] fwd_mid_ff;
   logic                 bypass_ff;
   logic                 bypass_in;

   assign bypass_in = ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
   assign top_gray  = bypass_ff ? fwd_top_ff : upper_q_ff;
   assign mid_gray  = bypass_ff ? fwd_mid_ff : middle_q_ff;

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         upper_q_ff  <= upper_mem[ctrl.rd_addr];
         middle_q_ff <= middle_mem[ctrl.rd_addr];
         fwd_top_ff  <= mid_gray;
         fwd_mid_ff  <= wr_gray;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         upper_mem[ctrl.wr_addr]  <= mid_gray;
         middle_mem[ctrl.wr_addr] <= wr_gray;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (ctrl.rd_en) begin
         bypass_ff <= bypass_in;
      end
   end

   `NDEM_ASSERT(a_bypass_on_hit, clock, reset,
      (ctrl.rd_en && ctrl.wr_en && ctrl.rd_addr == ctrl.wr_addr) |=> bypass_ff,
      "line buffer missed a same-address bypass")
   `NDEM_ASSERT(a_bypass_needs_read, clock, reset,
      (!ctrl.rd_en && !reset) |=> (bypass_ff == $past(bypass_ff)),
      "bypass flag changed without a read")
   `NDEM_ASSERT(a_no_bypass_without_write, clock, reset,
      (ctrl.rd_en && !ctrl.wr_en) |=> !bypass_ff,
      "bypass flag set without a write")

endmodule

`default_nettype wire

### design/neighbor_difference_edge_map_top.sv
// An accepted pixel's result (if any) passes the first stage and result registers to rsp_ch.
// Throughput: 1 pixel per cycle unless stalled; line buffer read and window shift per pixel.
// Results stall only when rsp_ch is full and not taken; req_ch.ready follows that.
// Reset: synchronous, active high; clears position, window, pipeline valids and
// sets image_cols 640, image_rows 480, edge_threshold 16. Line buffers are not cleared.
// ----------------------------------------------------------------------------
// Neighbor difference edge map top level
// Gray conversion, row/column tracking, 3x3 window and edge decision.
// ----------------------------------------------------------------------------
`default_nettype none
`include "neighbor_difference_edge_map_top_defines.svh"

module neighbor_difference_edge_map_top
   import ndem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   ndem_req_if.sink                  req_ch,
   ndem_rsp_if.source                rsp_ch,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output logic      [DATA_BITS-1:0] prdata,
   output logic                      pready
);

   // configuration registers
   logic [CFG_BITS-1:0]  cols_ff;
   logic [CFG_BITS-1:0]  rows_ff;
   logic [GRAY_BITS-1:0] thr_ff;
   logic                 cfg_write;
   logic [CFG_BITS-1:0]  cols_eff;
   logic [CFG_BITS-1:0]  rows_eff;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
         thr_ff  <= THRESHOLD_RESET;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_IMAGE_COLS:     cols_ff <= pwdata[CFG_BITS-1:0];
            REG_IMAGE_ROWS:     rows_ff <= pwdata[CFG_BITS-1:0];
            REG_EDGE_THRESHOLD: thr_ff  <= pwdata[GRAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_IMAGE_COLS:     prdata = DATA_BITS'(cols_ff);
         REG_IMAGE_ROWS:     prdata = DATA_BITS'(rows_ff);
         REG_EDGE_THRESHOLD: prdata = DATA_BITS'(thr_ff);
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      priority if (cols_ff < SIZE_MIN) cols_eff = SIZE_MIN;
      else if (cols_ff > COLS_MAX)     cols_eff = COLS_MAX;
      else                             cols_eff = cols_ff;
      priority if (rows_ff < SIZE_MIN) rows_eff = SIZE_MIN;
      else if (rows_ff > ROWS_MAX)     rows_eff = ROWS_MAX;
      else                             rows_eff = rows_ff;
   end

   // handshake
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   // position tracking
   logic [COL_BITS-1:0] col_cnt_ff;
   logic [COL_BITS-1:0] col_cnt_in;
   logic [ROW_BITS-1:0] row_cnt_ff;
   logic [ROW_BITS-1:0] row_cnt_in;
   logic [CFG_BITS-1:0] col_start;
   logic [CFG_BITS-1:0] row_start;
   logic [CFG_BITS-1:0] row_inc;
   logic [CFG_BITS-1:0] col_next;
   logic [CFG_BITS-1:0] row_next;
   logic [COL_BITS-1:0] cur_col;
   logic [ROW_BITS-1:0] cur_row;
   logic                wrap_in;

   always_comb begin
      col_start = req_ch.frame_start ? '0 : CFG_BITS'(col_cnt_ff);
      row_start = req_ch.frame_start ? '0 : CFG_BITS'(row_cnt_ff);
      wrap_in   = col_start >= cols_eff;
      cur_col   = wrap_in ? '0 : col_start[COL_BITS-1:0];
      row_inc   = wrap_in ? row_start + CFG_BITS'(1) : row_start;
      cur_row   = (row_inc >= rows_eff) ? '0 : row_inc[ROW_BITS-1:0];
      col_next  = CFG_BITS'(cur_col) + CFG_BITS'(1);
      row_next  = CFG_BITS'(cur_row) + CFG_BITS'(1);
      if (col_next >= cols_eff) begin
         col_cnt_in = '0;
         row_cnt_in = (row_next >= rows_eff) ? '0 : row_next[ROW_BITS-1:0];
      end else begin
         col_cnt_in = col_next[COL_BITS-1:0];
         row_cnt_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // gray conversion
   logic [ACC_BITS-1:0]  gray_acc;
   logic [GRAY_BITS-1:0] gray_in;

   assign gray_acc = ACC_BITS'(WEIGHT_RED) * ACC_BITS'(req_ch.red)
                   + ACC_BITS'(WEIGHT_GREEN) * ACC_BITS'(req_ch.green)
                   + ACC_BITS'(WEIGHT_BLUE) * ACC_BITS'(req_ch.blue);
   assign gray_in  = gray_acc[ACC_BITS-1:16];

   // first stage registers
   logic                 s1_valid_ff;
   logic [GRAY_BITS-1:0] s1_gray_ff;
   logic [COL_BITS-1:0]  s1_col_ff;
   logic                 s1_emit_ff;
   logic [POS_BITS-1:0]  s1_row_out_ff;
   logic [POS_BITS-1:0]  s1_col_out_ff;
   logic                 s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_gray_ff    <= gray_in;
         s1_col_ff     <= cur_col;
         s1_emit_ff    <= (cur_row >= ROW_BITS'(2)) && (cur_col >= COL_BITS'(2));
         s1_row_out_ff <= POS_BITS'(cur_row - ROW_BITS'(1));
         s1_col_out_ff <= POS_BITS'(cur_col - COL_BITS'(1));
         s1_last_ff    <= (CFG_BITS'(cur_row) == rows_eff - CFG_BITS'(1))
                       && (CFG_BITS'(cur_col) == cols_eff - CFG_BITS'(1));
      end
   end

   // line buffers
   lb_ctrl_type          lb_ctrl;
   logic [GRAY_BITS-1:0] top_gray;
   logic [GRAY_BITS-1:0] mid_gray;
   logic                 s1_step;

   assign s1_step         = advance && s1_valid_ff;
   assign lb_ctrl.rd_en   = accept;
   assign lb_ctrl.rd_addr = cur_col;
   assign lb_ctrl.wr_en   = s1_step;
   assign lb_ctrl.wr_addr = s1_col_ff;

   ndem_line_buf u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lb_ctrl),
      .wr_gray  (s1_gray_ff),
      .top_gray (top_gray),
      .mid_gray (mid_gray)
   );

   // window and edge decision
   logic [GRAY_BITS-1:0] win_ff [9];
   logic [GRAY_BITS-1:0] win_in [9];
   logic [GRAY_BITS:0]   diff   [9];
   logic [GRAY_BITS-1:0] mag    [9];
   logic                 edge_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]   = win_ff[k*3+1];
         win_in[k*3+1] = win_ff[k*3+2];
      end
      win_in[2] = top_gray;
      win_in[5] = mid_gray;
      win_in[8] = s1_gray_ff;
      edge_in   = 1'b0;
      for (int k = 0; k < 9; k++) begin
         diff[k] = {1'b0, win_in[k]} - {1'b0, win_in[4]};
         mag[k]  = diff[k][GRAY_BITS] ? GRAY_BITS'(-diff[k]) : diff[k][GRAY_BITS-1:0];
         if (k != 4 && mag[k] > thr_ff) begin
            edge_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_step) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // result register
   logic                rsp_valid_in;
   logic                rsp_edge_ff;
   logic [POS_BITS-1:0] rsp_row_ff;
   logic [POS_BITS-1:0] rsp_col_ff;
   logic                rsp_last_ff;

   assign rsp_valid_in = advance ? (s1_valid_ff && s1_emit_ff) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_step && s1_emit_ff) begin
         rsp_edge_ff <= edge_in;
         rsp_row_ff  <= s1_row_out_ff;
         rsp_col_ff  <= s1_col_out_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_red    = rsp_edge_ff ? COLOR_BLACK : COLOR_WHITE;
   assign rsp_ch.out_green  = rsp_edge_ff ? COLOR_BLACK : COLOR_WHITE;
   assign rsp_ch.out_blue   = rsp_edge_ff ? COLOR_BLACK : COLOR_WHITE;
   assign rsp_ch.edge_found = rsp_edge_ff;
   assign rsp_ch.pixel_row  = rsp_row_ff;
   assign rsp_ch.pixel_col  = rsp_col_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

   `NDEM_ASSERT(a_rsp_from_stage, clock, reset,
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_emit_ff),
      "result appeared without an interior pixel in flight")
   `NDEM_ASSERT(a_stage_holds, clock, reset,
      (s1_valid_ff && !advance) |=> s1_valid_ff,
      "pixel dropped from first stage during stall")
   `NDEM_ASSERT(a_interior_pos, clock, reset,
      (s1_valid_ff && s1_emit_ff) |-> (s1_row_out_ff != '0 && s1_col_out_ff != '0),
      "interior pixel tagged with a border position")
   `NDEM_ASSERT(a_last_col, clock, reset,
      (rsp_valid_ff && rsp_last_ff) |->
         (CFG_BITS'(rsp_col_ff) == cols_eff - CFG_BITS'(2)),
      "frame end flagged away from the last interior column")

endmodule

`default_nettype wire
